// File: rtl/mfa_pkg.sv
// ---------------------------------------------------------------------------
// mfa_pkg
// Shared types and constants for the 256-bit Montgomery field ALU.
// ---------------------------------------------------------------------------
package mfa_pkg;

    localparam int LIMB_W      = 64;
    localparam int FIELD_W     = 256;
    localparam int QUEUE_DEPTH = 4;
    localparam int PIPE_STAGES = 32;

    // Action codes carried in the input word.
    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_SQR = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_MOD0 = 3'd0;
    localparam logic [2:0] REG_MOD1 = 3'd1;
    localparam logic [2:0] REG_MOD2 = 3'd2;
    localparam logic [2:0] REG_MOD3 = 3'd3;
    localparam logic [2:0] REG_MINV = 3'd4;

    // Reset values: BN254 scalar field prime and its Montgomery constant.
    localparam logic [63:0] MOD0_RST = 64'd4891460686036598785;
    localparam logic [63:0] MOD1_RST = 64'd2896914383306846353;
    localparam logic [63:0] MOD2_RST = 64'd13281191951274694749;
    localparam logic [63:0] MOD3_RST = 64'd3486998266802970665;
    localparam logic [63:0] MINV_RST = 64'd14042775128853446655;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] a_limb0;
        logic [63:0] a_limb1;
        logic [63:0] a_limb2;
        logic [63:0] a_limb3;
        logic [63:0] b_limb0;
        logic [63:0] b_limb1;
        logic [63:0] b_limb2;
        logic [63:0] b_limb3;
    } mfa_in_t;

    typedef struct packed {
        logic [63:0] result_limb0;
        logic [63:0] result_limb1;
        logic [63:0] result_limb2;
        logic [63:0] result_limb3;
    } mfa_out_t;

    typedef struct packed {
        logic is_mul;
        logic is_add;
    } mfa_ctl_t;

    typedef struct packed {
        mfa_ctl_t     ctl;
        logic [255:0] a;
        logic [255:0] b;
    } mfa_cls_t;

    typedef struct packed {
        logic [255:0] p;
        logic [63:0]  minv;
    } mfa_cfg_t;

endpackage

// File: rtl/mfa_front.sv
// ---------------------------------------------------------------------------
// mfa_front
// Decodes the action of each input word into datapath controls.
// ---------------------------------------------------------------------------
module mfa_front (
    input  logic              in_valid,
    output logic              in_ready,
    input  mfa_pkg::mfa_in_t  in_data,
    output logic              push_valid,
    input  logic              push_ready,
    output mfa_pkg::mfa_cls_t push_data
);

    logic [255:0] op_a;
    logic [255:0] op_b;

    assign op_a = {in_data.a_limb3, in_data.a_limb2, in_data.a_limb1, in_data.a_limb0};
    assign op_b = {in_data.b_limb3, in_data.b_limb2, in_data.b_limb1, in_data.b_limb0};

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

    // Square is a multiply with the first operand on both sides.
    always_comb
    begin
        push_data.ctl.is_mul = (in_data.action == mfa_pkg::ACT_MUL) ||
                               (in_data.action == mfa_pkg::ACT_SQR);
        push_data.ctl.is_add = (in_data.action == mfa_pkg::ACT_ADD);
        push_data.a          = op_a;
        push_data.b          = (in_data.action == mfa_pkg::ACT_SQR) ? op_a : op_b;
    end

endmodule

// File: rtl/mfa_queue.sv
// ---------------------------------------------------------------------------
// mfa_queue
// Small FIFO between the decode front and the arithmetic pipeline.
// ---------------------------------------------------------------------------
module mfa_queue #(
    parameter int DEPTH = mfa_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  mfa_pkg::mfa_cls_t push_data,
    output logic              pop_valid,
    input  logic              pop,
    output mfa_pkg::mfa_cls_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfa_pkg::mfa_cls_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/mfa_back.sv
// ---------------------------------------------------------------------------
// mfa_back
// Pipelined datapath: 512-bit product, four Montgomery rounds, correction; add and subtract pass through.
// ---------------------------------------------------------------------------
module mfa_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mfa_pkg::mfa_cfg_t cfg,
    input  logic              q_valid,
    input  mfa_pkg::mfa_cls_t q_data,
    output logic              q_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output mfa_pkg::mfa_out_t res_data
);

    localparam int ROUNDS = 4;

    logic en;

    // Product stages
    logic              s0_v_reg, s1_v_reg, s2_v_reg, s3_v_reg;
    mfa_pkg::mfa_ctl_t s0_ctl_reg, s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic [511:0]      s0_ops_reg, s1_ops_reg, s2_ops_reg, s3_ops_reg;
    logic [63:0]       s0_pp_reg [8][8];
    logic [319:0]      s1_row_reg [8];
    logic [351:0]      s2_t4_reg [4];
    logic [415:0]      s3_t2_reg [2];

    // Round boundaries: index 0 is the full product, index g+1 after round g.
    logic              ac_v_reg   [ROUNDS+1];
    mfa_pkg::mfa_ctl_t ac_ctl_reg [ROUNDS+1];
    logic [511:0]      ac_r_reg   [ROUNDS+1];

    logic              ka_v_reg [ROUNDS], kb_v_reg [ROUNDS], kp_v_reg [ROUNDS];
    logic              rw_v_reg [ROUNDS], ks_v_reg [ROUNDS];
    mfa_pkg::mfa_ctl_t ka_ctl_reg [ROUNDS], kb_ctl_reg [ROUNDS], kp_ctl_reg [ROUNDS];
    mfa_pkg::mfa_ctl_t rw_ctl_reg [ROUNDS], ks_ctl_reg [ROUNDS];
    logic [511:0]      ka_r_reg [ROUNDS], kb_r_reg [ROUNDS], kp_r_reg [ROUNDS];
    logic [511:0]      rw_r_reg [ROUNDS], ks_r_reg [ROUNDS];
    logic [63:0]       ka_pl_reg [ROUNDS], ka_pm1_reg [ROUNDS], ka_pm2_reg [ROUNDS];
    logic [63:0]       kb_k_reg [ROUNDS];
    logic [63:0]       kp_pk_reg [ROUNDS][2][8];
    logic [287:0]      rw_row_reg [ROUNDS][2];
    logic [319:0]      ks_sum_reg [ROUNDS];

    // Final correction stages
    logic              f0_v_reg, f1_v_reg, res_v_reg;
    logic [255:0]      f0_x_reg, f0_y_reg;
    logic [255:0]      f1_d_reg;
    logic              f1_borrow_reg;
    logic [255:0]      res_reg;
    logic [256:0]      diff;
    logic [255:0]      fix;

    // The whole back end moves together unless a finished result is held.
    assign en        = !res_v_reg || res_ready;
    assign q_pop     = en && q_valid;
    assign res_valid = res_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg    <= 1'b0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            ac_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg    <= q_valid;
            s1_v_reg    <= s0_v_reg;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            ac_v_reg[0] <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_ctl_reg <= q_data.ctl;
            s0_ops_reg <= {q_data.b, q_data.a};
            for (int i = 0; i < 8; i++)
            begin
                for (int j = 0; j < 8; j++)
                begin
                    s0_pp_reg[i][j] <= 64'(q_data.a[32*i +: 32]) * 64'(q_data.b[32*j +: 32]);
                end
            end

            s1_ctl_reg <= s0_ctl_reg;
            s1_ops_reg <= s0_ops_reg;
            for (int i = 0; i < 8; i++)
            begin
                // Even and odd columns do not overlap, so each row is one add.
                s1_row_reg[i] <= {64'd0, s0_pp_reg[i][6], s0_pp_reg[i][4],
                                  s0_pp_reg[i][2], s0_pp_reg[i][0]} +
                                 {32'd0, s0_pp_reg[i][7], s0_pp_reg[i][5],
                                  s0_pp_reg[i][3], s0_pp_reg[i][1], 32'd0};
            end

            s2_ctl_reg <= s1_ctl_reg;
            s2_ops_reg <= s1_ops_reg;
            for (int k = 0; k < 4; k++)
            begin
                s2_t4_reg[k] <= {32'd0, s1_row_reg[2*k]} + {s1_row_reg[2*k+1], 32'd0};
            end

            s3_ctl_reg <= s2_ctl_reg;
            s3_ops_reg <= s2_ops_reg;
            for (int k = 0; k < 2; k++)
            begin
                s3_t2_reg[k] <= {64'd0, s2_t4_reg[2*k]} + {s2_t4_reg[2*k+1], 64'd0};
            end

            ac_ctl_reg[0] <= s3_ctl_reg;
            // Add and subtract words carry their operands down the pipe untouched.
            ac_r_reg[0]   <= s3_ctl_reg.is_mul ?
                             ({96'd0, s3_t2_reg[0]} + {s3_t2_reg[1][383:0], 128'd0}) :
                             s3_ops_reg;
        end
    end

    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_round
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ka_v_reg[g]   <= 1'b0;
                kb_v_reg[g]   <= 1'b0;
                kp_v_reg[g]   <= 1'b0;
                rw_v_reg[g]   <= 1'b0;
                ks_v_reg[g]   <= 1'b0;
                ac_v_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                ka_v_reg[g]   <= ac_v_reg[g];
                kb_v_reg[g]   <= ka_v_reg[g];
                kp_v_reg[g]   <= kb_v_reg[g];
                rw_v_reg[g]   <= kp_v_reg[g];
                ks_v_reg[g]   <= rw_v_reg[g];
                ac_v_reg[g+1] <= ks_v_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // Quotient digit k = limb g times minv, low 64 bits only.
                ka_ctl_reg[g] <= ac_ctl_reg[g];
                ka_r_reg[g]   <= ac_r_reg[g];
                ka_pl_reg[g]  <= 64'(ac_r_reg[g][64*g +: 32]) * 64'(cfg.minv[31:0]);
                ka_pm1_reg[g] <= 64'(ac_r_reg[g][64*g +: 32]) * 64'(cfg.minv[63:32]);
                ka_pm2_reg[g] <= 64'(ac_r_reg[g][64*g+32 +: 32]) * 64'(cfg.minv[31:0]);

                kb_ctl_reg[g] <= ka_ctl_reg[g];
                kb_r_reg[g]   <= ka_r_reg[g];
                kb_k_reg[g]   <= ka_pl_reg[g] +
                                 {ka_pm1_reg[g][31:0] + ka_pm2_reg[g][31:0], 32'd0};

                kp_ctl_reg[g] <= kb_ctl_reg[g];
                kp_r_reg[g]   <= kb_r_reg[g];
                for (int t = 0; t < 2; t++)
                begin
                    for (int j = 0; j < 8; j++)
                    begin
                        kp_pk_reg[g][t][j] <= 64'(kb_k_reg[g][32*t +: 32]) *
                                              64'(cfg.p[32*j +: 32]);
                    end
                end

                rw_ctl_reg[g] <= kp_ctl_reg[g];
                rw_r_reg[g]   <= kp_r_reg[g];
                for (int t = 0; t < 2; t++)
                begin
                    rw_row_reg[g][t] <= {32'd0, kp_pk_reg[g][t][6], kp_pk_reg[g][t][4],
                                         kp_pk_reg[g][t][2], kp_pk_reg[g][t][0]} +
                                        {kp_pk_reg[g][t][7], kp_pk_reg[g][t][5],
                                         kp_pk_reg[g][t][3], kp_pk_reg[g][t][1], 32'd0};
                end

                ks_ctl_reg[g] <= rw_ctl_reg[g];
                ks_r_reg[g]   <= rw_r_reg[g];
                ks_sum_reg[g] <= {32'd0, rw_row_reg[g][0]} + {rw_row_reg[g][1], 32'd0};

                // The carry out of bit 511 is dropped.
                ac_ctl_reg[g+1] <= ks_ctl_reg[g];
                ac_r_reg[g+1]   <= ks_ctl_reg[g].is_mul ?
                                   ks_r_reg[g] + ({192'd0, ks_sum_reg[g]} << (64 * g)) :
                                   ks_r_reg[g];
            end
        end
    end

    assign diff = {1'b0, f0_x_reg} - {1'b0, f0_y_reg};
    assign fix  = f1_borrow_reg ? cfg.p : 256'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_v_reg  <= 1'b0;
            f1_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f0_v_reg  <= ac_v_reg[ROUNDS];
            f1_v_reg  <= f0_v_reg;
            res_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ac_ctl_reg[ROUNDS].is_add)
            begin
                f0_x_reg <= ac_r_reg[ROUNDS][255:0] + ac_r_reg[ROUNDS][511:256];
            end
            else if (ac_ctl_reg[ROUNDS].is_mul)
            begin
                f0_x_reg <= ac_r_reg[ROUNDS][511:256];
            end
            else
            begin
                f0_x_reg <= ac_r_reg[ROUNDS][255:0];
            end
            f0_y_reg <= (ac_ctl_reg[ROUNDS].is_add || ac_ctl_reg[ROUNDS].is_mul) ?
                        cfg.p : ac_r_reg[ROUNDS][511:256];

            f1_d_reg      <= diff[255:0];
            f1_borrow_reg <= diff[256];

            res_reg <= f1_d_reg + fix;
        end
    end

    always_comb
    begin
        res_data.result_limb0 = res_reg[63:0];
        res_data.result_limb1 = res_reg[127:64];
        res_data.result_limb2 = res_reg[191:128];
        res_data.result_limb3 = res_reg[255:192];
    end

endmodule

// File: rtl/montgomery_field_alu_256_top.sv
// ---------------------------------------------------------------------------
// montgomery_field_alu_256_top
// 256-bit prime-field ALU: modular add, subtract, Montgomery multiply/square.
// ---------------------------------------------------------------------------
// A word is written into the queue, then passes the product stages, the rounds and the correction stages.
// Throughput: one word per cycle; every stage of the back pipeline is fully
// parallel, and a held result freezes the back pipeline while the queue fills.
// Reset clears all valid bits and loads the BN254 scalar field modulus.
module montgomery_field_alu_256_top #(
    parameter int QUEUE_DEPTH = mfa_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mfa_pkg::mfa_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mfa_pkg::mfa_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);

    logic [63:0]       mod_reg [4];
    logic [63:0]       minv_reg;
    mfa_pkg::mfa_cfg_t cfg;

    logic              push_valid, push_ready;
    mfa_pkg::mfa_cls_t push_data;
    logic              pop_valid, pop;
    mfa_pkg::mfa_cls_t pop_data;

    assign cfg_ready = 1'b1;
    assign cfg.p     = {mod_reg[3], mod_reg[2], mod_reg[1], mod_reg[0]};
    assign cfg.minv  = minv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg[0] <= mfa_pkg::MOD0_RST;
            mod_reg[1] <= mfa_pkg::MOD1_RST;
            mod_reg[2] <= mfa_pkg::MOD2_RST;
            mod_reg[3] <= mfa_pkg::MOD3_RST;
            minv_reg   <= mfa_pkg::MINV_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mfa_pkg::REG_MOD0: mod_reg[0] <= cfg_data;
                mfa_pkg::REG_MOD1: mod_reg[1] <= cfg_data;
                mfa_pkg::REG_MOD2: mod_reg[2] <= cfg_data;
                mfa_pkg::REG_MOD3: mod_reg[3] <= cfg_data;
                mfa_pkg::REG_MINV: minv_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    mfa_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    mfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (pop_valid),
        .q_data    (pop_data),
        .q_pop     (pop),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res_data  (out_data)
    );

endmodule

// File: rtl/mfa_checker.sv
// ---------------------------------------------------------------------------
// mfa_checker
// Port-level checks for the Montgomery field ALU, bound to the top level.
// ---------------------------------------------------------------------------
module mfa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input mfa_pkg::mfa_out_t out_data,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    logic [7:0] pending_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Words accepted whose results have not yet been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (!in_acc && out_acc)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("result word with no pending input");

    a_cfg_always: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken");

endmodule

bind montgomery_field_alu_256_top mfa_checker u_mfa_checker (.*);

// File: test/tb_montgomery_field_alu_256_top.sv
// ---------------------------------------------------------------------------
// tb_montgomery_field_alu_256_top
// Streams field operations through the ALU and compares each result word
// against a behavioral prediction, under several modulus settings and
// varying handshake pressure on both channels.
// ---------------------------------------------------------------------------
module tb_montgomery_field_alu_256_top;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    mfa_pkg::mfa_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    mfa_pkg::mfa_out_t out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [63:0]       cfg_data;

    montgomery_field_alu_256_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam logic [255:0] BN_P = {mfa_pkg::MOD3_RST, mfa_pkg::MOD2_RST,
                                     mfa_pkg::MOD1_RST, mfa_pkg::MOD0_RST};
    localparam logic [255:0] ONES = {256{1'b1}};

    // Predictor copy of the configuration.
    logic [255:0] field_p;
    logic [63:0]  field_minv;

    mfa_pkg::mfa_out_t pending_results[$];
    int errors;
    int send_idle_pct;
    int recv_idle_pct;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #50000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [255:0] sub_correct(logic [255:0] x, logic [255:0] y);
        logic [256:0] d;
        d = {1'b0, x} - {1'b0, y};
        // A borrow out of the top adds the modulus back, carry dropped.
        if (d[256])
            return d[255:0] + field_p;
        return d[255:0];
    endfunction

    function automatic logic [255:0] mont_product(logic [255:0] x, logic [255:0] y);
        logic [63:0]  r[8];
        logic [511:0] prod;
        logic [127:0] t;
        logic [63:0]  k;
        logic [63:0]  carry;
        logic [1:0]   c2;
        prod = {256'd0, x} * {256'd0, y};
        for (int i = 0; i < 8; i++)
            r[i] = prod[64*i +: 64];
        c2 = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            k = r[i] * field_minv;
            carry = 64'd0;
            for (int j = 0; j < 4; j++)
            begin
                t = {64'd0, r[i+j]} + {64'd0, k} * {64'd0, field_p[64*j +: 64]}
                    + {64'd0, carry};
                r[i+j] = t[63:0];
                carry = t[127:64];
            end
            // Sum of three words can carry 0..2; the top round's carry is lost.
            t = {64'd0, r[i+4]} + {64'd0, carry} + {126'd0, c2};
            r[i+4] = t[63:0];
            c2 = t[65:64];
        end
        return sub_correct({r[7], r[6], r[5], r[4]}, field_p);
    endfunction

    function automatic mfa_pkg::mfa_out_t field_result(mfa_pkg::mfa_in_t w);
        logic [255:0] a, b, r;
        mfa_pkg::mfa_out_t o;
        a = {w.a_limb3, w.a_limb2, w.a_limb1, w.a_limb0};
        b = {w.b_limb3, w.b_limb2, w.b_limb1, w.b_limb0};
        case (w.action)
            mfa_pkg::ACT_ADD: r = sub_correct(a + b, field_p);
            mfa_pkg::ACT_SUB: r = sub_correct(a, b);
            mfa_pkg::ACT_MUL: r = mont_product(a, b);
            default:          r = mont_product(a, a);
        endcase
        o.result_limb0 = r[63:0];
        o.result_limb1 = r[127:64];
        o.result_limb2 = r[191:128];
        o.result_limb3 = r[255:192];
        return o;
    endfunction

    function automatic mfa_pkg::mfa_in_t make_word(logic [1:0] act, logic [255:0] a,
                                                   logic [255:0] b);
        mfa_pkg::mfa_in_t w;
        w.action = act;
        {w.a_limb3, w.a_limb2, w.a_limb1, w.a_limb0} = a;
        {w.b_limb3, w.b_limb2, w.b_limb1, w.b_limb0} = b;
        return w;
    endfunction

    function automatic logic [255:0] rand_256();
        logic [255:0] v;
        for (int i = 0; i < 8; i++)
            v[32*i +: 32] = $urandom;
        return v;
    endfunction

    // Random value mostly below the modulus, sometimes anything at all.
    function automatic logic [255:0] rand_operand();
        logic [255:0] v;
        case ($urandom_range(0, 9))
            0: v = ONES;
            1: v = 256'd0;
            2: v = rand_256();
            3: v = field_p - 256'($urandom_range(1, 4));
            default:
            begin
                v = rand_256();
                if (field_p != 0)
                    v = v % field_p;
            end
        endcase
        return v;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result word %h", out_data);
            end
            else
            begin
                mfa_pkg::mfa_out_t e;
                e = pending_results.pop_front();
                if (out_data !== e)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected %h %h %h %h, got %h %h %h %h",
                                 e.result_limb3, e.result_limb2, e.result_limb1,
                                 e.result_limb0, out_data.result_limb3,
                                 out_data.result_limb2, out_data.result_limb1,
                                 out_data.result_limb0);
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Valid stays high between back-to-back words; it drops only in idle cycles.
    task automatic send_word(mfa_pkg::mfa_in_t w, bit has_known, mfa_pkg::mfa_out_t known);
        mfa_pkg::mfa_out_t p;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = field_result(w);
        if (has_known && p !== known)
        begin
            errors++;
            if (errors <= 10)
                $display("Table row disagrees with prediction: %h vs %h", known, p);
        end
        pending_results.push_back(p);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < mfa_pkg::REG_MINV)
            field_p[64*idx +: 64] = val;
        else if (idx == mfa_pkg::REG_MINV)
            field_minv = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_field(logic [255:0] p, logic [63:0] minv);
        write_reg(mfa_pkg::REG_MOD0, p[63:0]);
        write_reg(mfa_pkg::REG_MOD1, p[127:64]);
        write_reg(mfa_pkg::REG_MOD2, p[191:128]);
        write_reg(mfa_pkg::REG_MOD3, p[255:192]);
        write_reg(mfa_pkg::REG_MINV, minv);
    endtask

    // -p^-1 mod 2^64 by Newton iteration; only the low limb matters.
    function automatic logic [63:0] neg_inverse(logic [63:0] p0);
        logic [63:0] x;
        x = 64'd1;
        for (int i = 0; i < 7; i++)
            x = x * (64'd2 - p0 * x);
        return -x;
    endfunction

    typedef struct {
        logic [1:0]   act;
        logic [255:0] a;
        logic [255:0] b;
        bit           known;
        logic [255:0] res;
    } row_t;

    task automatic random_phase(int n);
        logic [1:0] act;
        mfa_pkg::mfa_out_t dummy;
        for (int i = 0; i < n; i++)
        begin
            act = 2'($urandom_range(0, 3));
            send_word(make_word(act, rand_operand(), rand_operand()), 1'b0, dummy);
        end
    endtask

    initial
    begin
        row_t rows[$];
        mfa_pkg::mfa_out_t kn;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        send_idle_pct = 9;
        recv_idle_pct = 80;
        field_p = BN_P;
        field_minv = mfa_pkg::MINV_RST;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        rows.push_back('{mfa_pkg::ACT_ADD, 256'd0, 256'd0, 1, 256'd0});
        rows.push_back('{mfa_pkg::ACT_ADD, BN_P - 1, 256'd1, 1, 256'd0});
        rows.push_back('{mfa_pkg::ACT_ADD, BN_P - 1, BN_P - 1, 1, BN_P - 2});
        rows.push_back('{mfa_pkg::ACT_SUB, 256'd5, 256'd5, 1, 256'd0});
        rows.push_back('{mfa_pkg::ACT_SUB, 256'd0, 256'd1, 1, BN_P - 1});
        rows.push_back('{mfa_pkg::ACT_SUB, 256'd7, 256'd3, 1, 256'd4});
        rows.push_back('{mfa_pkg::ACT_MUL, 256'd0, BN_P - 1, 1, 256'd0});
        rows.push_back('{mfa_pkg::ACT_SQR, 256'd0, ONES, 1, 256'd0});
        rows.push_back('{mfa_pkg::ACT_MUL, BN_P - 1, BN_P - 1, 0, 0});
        rows.push_back('{mfa_pkg::ACT_MUL, 256'd1, 256'd1, 0, 0});
        rows.push_back('{mfa_pkg::ACT_SQR, BN_P - 1, 256'd0, 0, 0});
        rows.push_back('{mfa_pkg::ACT_ADD, ONES, ONES, 0, 0});
        rows.push_back('{mfa_pkg::ACT_SUB, 256'd0, ONES, 0, 0});
        rows.push_back('{mfa_pkg::ACT_MUL, ONES, ONES, 0, 0});
        rows.push_back('{mfa_pkg::ACT_SQR, ONES, ONES, 0, 0});
        rows.push_back('{mfa_pkg::ACT_ADD, ONES, 256'd1, 0, 0});
        foreach (rows[i])
        begin
            kn.result_limb0 = rows[i].res[63:0];
            kn.result_limb1 = rows[i].res[127:64];
            kn.result_limb2 = rows[i].res[191:128];
            kn.result_limb3 = rows[i].res[255:192];
            send_word(make_word(rows[i].act, rows[i].a, rows[i].b), rows[i].known, kn);
        end
        random_phase(200);
        // Hold the sender until the pipeline is empty.
        drain();

        send_idle_pct = 80;
        recv_idle_pct = 9;
        set_field({64'h7FFF_FFFF_FFFF_FFFF, {3{64'hFFFF_FFFF_FFFF_FFFF}}},
                  neg_inverse(64'hFFFF_FFFF_FFFF_FFFF));
        random_phase(150);
        drain();

        // Deliberately wrong inverse and an out-of-range index that is ignored.
        set_field({192'd0, 64'd3}, 64'h0);
        write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(100);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_field(ONES, 64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(100);
        drain();
        set_field(BN_P, mfa_pkg::MINV_RST);
        random_phase(250);
        drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
